// ----- hw/rtl/sli_pkg.sv -----
// shared constants and types for the sorted insertion list
package sli_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INS_LAST,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/sli_ram.sv -----
// generic single-write, single-read ram with registered read data
module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sorted_list_insert_delete.sv -----
// sorted insertion list: ascending table of signed values with insert and delete
// insert scans down from the last entry, moving entries not smaller than value up one place;
// delete scans every entry; full-table insert and empty-table delete go straight to the result
// one item at a time: req_stall is high from acceptance until the result register loads
// reset clears the used count and control; entry_count, status and ram contents are left as they are
module sorted_list_insert_delete (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               cmd,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic [6:0]         entry_count
);
  import sli_pkg::*;

  state_t             state, state_next;
  logic               cmd_r, cmd_r_next;
  logic signed [31:0] val_r, val_r_next;
  logic [CNT_W-1:0]   used, used_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic               rd_more, rd_more_next;
  logic               d_vld, d_vld_next;
  logic [IDX_W-1:0]   d_idx, d_idx_next;
  logic               found, found_next;
  status_t            res_status, res_status_next;
  logic               rsp_valid_next;
  logic [1:0]         status_next;
  logic [6:0]         entry_count_next;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [31:0]        wdata;
  logic [31:0]        rdata;

  sli_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      rd_more    <= 1'b0;
      d_vld      <= 1'b0;
      found      <= 1'b0;
      rsp_valid  <= 1'b0;
      res_status <= ST_DONE;
    end else begin
      state      <= state_next;
      used       <= used_next;
      rd_more    <= rd_more_next;
      d_vld      <= d_vld_next;
      found      <= found_next;
      rsp_valid  <= rsp_valid_next;
      res_status <= res_status_next;
    end
    cmd_r       <= cmd_r_next;
    val_r       <= val_r_next;
    rd_idx      <= rd_idx_next;
    d_idx       <= d_idx_next;
    status      <= status_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next       = state;
    cmd_r_next       = cmd_r;
    val_r_next       = val_r;
    used_next        = used;
    rd_idx_next      = rd_idx;
    rd_more_next     = rd_more;
    d_vld_next       = 1'b0;
    d_idx_next       = d_idx;
    found_next       = found;
    res_status_next  = res_status;
    rsp_valid_next   = rsp_valid && rsp_stall;
    status_next      = status;
    entry_count_next = entry_count;
    we               = 1'b0;
    waddr            = d_idx + IDX_W'(1);
    wdata            = rdata;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_r_next   = cmd;
          val_r_next   = value;
          found_next   = 1'b0;
          rd_more_next = 1'b1;
          if (cmd == CMD_INSERT) begin
            rd_idx_next = IDX_W'(used - CNT_W'(1));
            if (used == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (used == '0) begin
              state_next = S_INS_LAST;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            rd_idx_next = '0;
            if (used == '0) begin
              res_status_next = ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_more) begin
          d_vld_next = 1'b1;
          d_idx_next = rd_idx;
          if (cmd_r == CMD_INSERT) begin
            if (rd_idx == '0) begin
              rd_more_next = 1'b0;
            end else begin
              rd_idx_next = rd_idx - IDX_W'(1);
            end
          end else begin
            if (rd_idx == IDX_W'(used - CNT_W'(1))) begin
              rd_more_next = 1'b0;
            end else begin
              rd_idx_next = rd_idx + IDX_W'(1);
            end
          end
        end
        if (d_vld) begin
          if (cmd_r == CMD_INSERT) begin
            we    = 1'b1;
            waddr = d_idx + IDX_W'(1);
            if ($signed(rdata) >= val_r) begin
              wdata = rdata;
              if (d_idx == '0) begin
                state_next = S_INS_LAST;
                d_vld_next = 1'b0;
              end
            end else begin
              wdata           = val_r;
              used_next       = used + CNT_W'(1);
              res_status_next = ST_DONE;
              state_next      = S_DONE;
              d_vld_next      = 1'b0;
            end
          end else begin
            if (!found && ($signed(rdata) == val_r)) begin
              found_next = 1'b1;
            end else if (found) begin
              we    = 1'b1;
              waddr = d_idx - IDX_W'(1);
              wdata = rdata;
            end
            if (d_idx == IDX_W'(used - CNT_W'(1))) begin
              state_next = S_DONE;
              d_vld_next = 1'b0;
              if (found_next) begin
                used_next       = used - CNT_W'(1);
                res_status_next = ST_DONE;
              end else begin
                res_status_next = ST_NOT_FOUND;
              end
            end
          end
        end
      end
      S_INS_LAST: begin
        we              = 1'b1;
        waddr           = '0;
        wdata           = val_r;
        used_next       = used + CNT_W'(1);
        res_status_next = ST_DONE;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next   = 1'b1;
          status_next      = res_status;
          entry_count_next = 7'(used);
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_SCAN || state == S_INS_LAST))
    else $error("ram write while not working on an item");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> entry_count == 7'(CAPACITY))
    else $error("full status with table not full");

endmodule
